>>> sv/dta_pkg.sv
`timescale 1ns / 1ps

package dta_pkg;

    localparam int SAMPLE_W = 32;
    localparam int LEN_W    = 7;
    localparam int LIMIT_W  = 32;
    localparam int LEVEL_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    // At most 127 samples of 32 bits are summed, so the total needs 39 bits signed
    // and its magnitude fits in 38 bits.
    localparam int TOTAL_W = SAMPLE_W + LEN_W;
    localparam int MAG_W   = TOTAL_W - 1;
    localparam int REM_W   = LEN_W + 1;
    localparam int DIV_CNT_W = $clog2(MAG_W);

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [LEN_W-1:0]           len_t;
    typedef logic [LIMIT_W-1:0]         limit_t;
    typedef logic [LEVEL_W-1:0]         level_t;
    typedef logic signed [TOTAL_W-1:0]  total_t;
    typedef logic [MAG_W-1:0]           mag_t;

    localparam level_t LEVEL_NORMAL = 2'd0;
    localparam level_t LEVEL_WARN   = 2'd1;
    localparam level_t LEVEL_KILL   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_AVG_LEN     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KILL_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WARN_LIMIT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KILL_ENABLE = 2'd3;

    localparam len_t     AVG_LEN_RESET    = 7'd8;
    localparam limit_t   KILL_LIMIT_RESET = 32'd1000;
    localparam limit_t   WARN_LIMIT_RESET = 32'd250;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

>>> sv/drift_average_threshold_alarm.sv
`timescale 1ns / 1ps

// Moving average of signed drift samples with a two-level threshold alarm.
// Samples enter on sample_valid/sample_stall; results leave on
// result_valid/result_stall with smoothed_drift, alarm_level and kill_fire.
// A request is taken when valid is high and stall is low.
// Registers are written over cfg_valid/cfg_ready with cfg_index and cfg_data;
// the user must write them only while idle; the block itself does not enforce it.
// cfg_ready is always high. Writing avg_len restarts the window; until it fills,
// only the samples written since the restart are averaged. An avg_len of zero
// passes the sample through. Averaging takes the sample through the subtract,
// add and absolute-value steps that update the running total and ring and load
// the divider, then through the restoring divider (one quotient bit per cycle
// over 38 bits, then its done flag), then the compare step. Pass-through goes
// straight to the compare step. A new sample can be taken in the cycle the
// result appears, so only one sample is in work at a time. If the receiver
// stalls, the result is held and the next result waits in the compare step
// until the output register is free.
// Reset restores the register defaults, empties the window and clears the kill
// latch; ring contents are not cleared and need no clearing pass.

module drift_average_threshold_alarm #(
    parameter int WINDOW_DEPTH = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               sample_valid,
    output logic                               sample_stall,
    input  logic signed [dta_pkg::SAMPLE_W-1:0] drift_sample,
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic signed [dta_pkg::SAMPLE_W-1:0] smoothed_drift,
    output logic [dta_pkg::LEVEL_W-1:0]        alarm_level,
    output logic                               kill_fire,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [dta_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dta_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int SLOT_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int LEN_CAP = (WINDOW_DEPTH > 127) ? 127 : WINDOW_DEPTH;
    localparam int CMP_W   = ((SLOT_W > dta_pkg::LEN_W) ? SLOT_W : dta_pkg::LEN_W) + 1;
    localparam dta_pkg::len_t LEN_CAP_V = dta_pkg::LEN_W'(LEN_CAP);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SUB  = 6'b000010,
        ST_ADD  = 6'b000100,
        ST_ABS  = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_CMP  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    dta_pkg::len_t    avg_len_reg;
    dta_pkg::limit_t  kill_limit_reg;
    dta_pkg::limit_t  warn_limit_reg;
    logic             kill_enable_reg;

    logic [SLOT_W-1:0] write_slot_reg, write_slot_next;
    dta_pkg::len_t     fill_count_reg, fill_count_next;
    dta_pkg::total_t   total_reg, total_next;
    logic              kill_latched_reg, kill_latched_next;

    dta_pkg::sample_t  sample_reg;
    dta_pkg::sample_t  smoothed_reg, smoothed_next;
    dta_pkg::limit_t   mag_reg, mag_next;
    logic              neg_reg;

    logic              result_valid_reg, result_valid_next;
    dta_pkg::sample_t  result_data_reg;
    dta_pkg::level_t   level_reg, level_next;
    logic              fire_reg, fire_next;

    dta_pkg::len_t     len;
    logic              full;
    logic              accept;
    logic              cfg_write;
    logic              out_free;
    dta_pkg::total_t   total_abs;
    dta_pkg::sample_t  ring_rd_data;
    logic              ring_wr_en;
    logic              div_start;
    dta_pkg::mag_t     div_quotient;
    dta_pkg::div_status_t div_status;

    assign len       = (avg_len_reg > LEN_CAP_V) ? LEN_CAP_V : avg_len_reg;
    assign full      = (fill_count_reg >= len);
    assign accept    = sample_valid && !sample_stall;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign out_free  = !result_valid_reg || !result_stall;
    assign total_abs = total_reg[dta_pkg::TOTAL_W-1] ? -total_reg : total_reg;
    assign ring_wr_en = (state_reg == ST_ADD);
    assign div_start  = (state_reg == ST_ABS);

    dta_ring #(
        .DEPTH  (WINDOW_DEPTH),
        .ADDR_W (SLOT_W)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ring_wr_en),
        .wr_addr (write_slot_reg),
        .wr_data (sample_reg),
        .rd_addr (write_slot_reg),
        .rd_data (ring_rd_data)
    );

    dta_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (total_abs[dta_pkg::MAG_W-1:0]),
        .divisor  (fill_count_reg),
        .quotient (div_quotient),
        .status   (div_status)
    );

    always_comb
    begin
        state_next        = state_reg;
        write_slot_next   = write_slot_reg;
        fill_count_next   = fill_count_reg;
        total_next        = total_reg;
        kill_latched_next = kill_latched_reg;
        smoothed_next     = smoothed_reg;
        mag_next          = mag_reg;
        result_valid_next = result_valid_reg && result_stall;
        level_next        = dta_pkg::LEVEL_NORMAL;
        fire_next         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (len == '0)
                    begin
                        smoothed_next = drift_sample;
                        mag_next = drift_sample[dta_pkg::SAMPLE_W-1] ?
                                   dta_pkg::LIMIT_W'(-drift_sample) :
                                   dta_pkg::LIMIT_W'(drift_sample);
                        state_next = ST_CMP;
                    end
                    else
                    begin
                        state_next = ST_SUB;
                    end
                end
            end
            ST_SUB:
            begin
                // The slot being overwritten leaves the sum once the window is full.
                if (full)
                begin
                    total_next = total_reg - dta_pkg::TOTAL_W'(ring_rd_data);
                end
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                total_next = total_reg + dta_pkg::TOTAL_W'(sample_reg);
                if (CMP_W'(write_slot_reg) + CMP_W'(1) >= CMP_W'(len))
                begin
                    write_slot_next = '0;
                end
                else
                begin
                    write_slot_next = write_slot_reg + 1'b1;
                end
                if (!full)
                begin
                    fill_count_next = fill_count_reg + 1'b1;
                end
                state_next = ST_ABS;
            end
            ST_ABS:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_status.done)
                begin
                    mag_next = div_quotient[dta_pkg::LIMIT_W-1:0];
                    smoothed_next = neg_reg ?
                                    -dta_pkg::SAMPLE_W'(div_quotient[dta_pkg::SAMPLE_W-1:0]) :
                                    dta_pkg::SAMPLE_W'(div_quotient[dta_pkg::SAMPLE_W-1:0]);
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (out_free)
                begin
                    result_valid_next = 1'b1;
                    if (mag_reg >= kill_limit_reg)
                    begin
                        level_next = dta_pkg::LEVEL_KILL;
                        if (!kill_latched_reg && kill_enable_reg)
                        begin
                            kill_latched_next = 1'b1;
                            fire_next = 1'b1;
                        end
                    end
                    else if (mag_reg >= warn_limit_reg)
                    begin
                        level_next = dta_pkg::LEVEL_WARN;
                    end
                    else
                    begin
                        level_next = dta_pkg::LEVEL_NORMAL;
                        kill_latched_next = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_write && cfg_index == dta_pkg::CFG_AVG_LEN)
        begin
            write_slot_next = '0;
            fill_count_next = '0;
            total_next      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            avg_len_reg      <= dta_pkg::AVG_LEN_RESET;
            kill_limit_reg   <= dta_pkg::KILL_LIMIT_RESET;
            warn_limit_reg   <= dta_pkg::WARN_LIMIT_RESET;
            kill_enable_reg  <= 1'b0;
            write_slot_reg   <= '0;
            fill_count_reg   <= '0;
            total_reg        <= '0;
            kill_latched_reg <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            write_slot_reg   <= write_slot_next;
            fill_count_reg   <= fill_count_next;
            total_reg        <= total_next;
            kill_latched_reg <= kill_latched_next;
            result_valid_reg <= result_valid_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    dta_pkg::CFG_AVG_LEN:     avg_len_reg     <= cfg_data[dta_pkg::LEN_W-1:0];
                    dta_pkg::CFG_KILL_LIMIT:  kill_limit_reg  <= cfg_data[dta_pkg::LIMIT_W-1:0];
                    dta_pkg::CFG_WARN_LIMIT:  warn_limit_reg  <= cfg_data[dta_pkg::LIMIT_W-1:0];
                    dta_pkg::CFG_KILL_ENABLE: kill_enable_reg <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= drift_sample;
        end
        if (state_reg == ST_ABS)
        begin
            neg_reg <= total_reg[dta_pkg::TOTAL_W-1];
        end
        smoothed_reg <= smoothed_next;
        mag_reg      <= mag_next;
        if (state_reg == ST_CMP && out_free)
        begin
            result_data_reg <= smoothed_reg;
            level_reg       <= level_next;
            fire_reg        <= fire_next;
        end
    end

    assign sample_stall   = (state_reg != ST_IDLE);
    assign result_valid   = result_valid_reg;
    assign smoothed_drift = result_data_reg;
    assign alarm_level    = level_reg;
    assign kill_fire      = fire_reg;

endmodule

>>> sv/dta_ring.sv
`timescale 1ns / 1ps

module dta_ring #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic                    clk,
    input  logic                    wr_en,
    input  logic [ADDR_W-1:0]       wr_addr,
    input  dta_pkg::sample_t        wr_data,
    input  logic [ADDR_W-1:0]       rd_addr,
    output dta_pkg::sample_t        rd_data
);

    dta_pkg::sample_t mem [DEPTH];
    dta_pkg::sample_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/dta_divider.sv
`timescale 1ns / 1ps

module dta_divider (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  dta_pkg::mag_t         dividend,
    input  dta_pkg::len_t         divisor,
    output dta_pkg::mag_t         quotient,
    output dta_pkg::div_status_t  status
);

    dta_pkg::mag_t                    quo_reg, quo_next;
    logic [dta_pkg::REM_W-1:0]        rem_reg, rem_next;
    logic [dta_pkg::DIV_CNT_W-1:0]    cnt_reg, cnt_next;
    logic                             busy_reg, busy_next;
    logic                             done_reg, done_next;
    logic [dta_pkg::REM_W-1:0]        shifted;
    logic [dta_pkg::REM_W:0]          trial;
    dta_pkg::len_t                    divisor_hold_reg;

    // Restoring division, one quotient bit per cycle.
    always_comb
    begin
        shifted   = {rem_reg[dta_pkg::REM_W-2:0], quo_reg[dta_pkg::MAG_W-1]};
        trial     = {1'b0, shifted} - {2'b00, divisor_hold_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = dta_pkg::DIV_CNT_W'(dta_pkg::MAG_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[dta_pkg::MAG_W-2:0], ~trial[dta_pkg::REM_W]};
            rem_next = trial[dta_pkg::REM_W] ? shifted : trial[dta_pkg::REM_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        if (start)
        begin
            divisor_hold_reg <= divisor;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

>>> sv/dta_checker.sv
`timescale 1ns / 1ps

module dta_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                sample_valid,
    input logic                                sample_stall,
    input logic                                result_valid,
    input logic                                result_stall,
    input logic [dta_pkg::LEVEL_W-1:0]         alarm_level,
    input logic                                kill_fire
);

    // A held result keeps its flag while the receiver stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
    else $error("result dropped while stalled");

    // Only one sample is in work at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !sample_stall |=> sample_stall)
    else $error("sample taken while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> alarm_level == dta_pkg::LEVEL_NORMAL ||
                         alarm_level == dta_pkg::LEVEL_WARN ||
                         alarm_level == dta_pkg::LEVEL_KILL)
    else $error("alarm level out of range");

    // A kill pulse only accompanies the kill level.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && kill_fire |-> alarm_level == dta_pkg::LEVEL_KILL)
    else $error("kill pulse without kill level");

endmodule

bind drift_average_threshold_alarm dta_checker u_dta_checker (.*);
